// ===== design/i2cm_pkg.sv =====
// shared types and codes for the i2c bit-level master
// holds item and result beat types, action codes and bus phase codes
// no dependencies
package i2cm_pkg;

  // action codes of an input beat
  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_XFER  = 3'd1;
  localparam logic [2:0] ACT_PROBE = 3'd2;
  localparam logic [2:0] ACT_WRITE = 3'd3;
  localparam logic [2:0] ACT_READ  = 3'd4;

  // bus phases of the sequencer
  localparam logic [3:0] PH_IDLE       = 4'd0;
  localparam logic [3:0] PH_START_LOW  = 4'd1;
  localparam logic [3:0] PH_RS_HIGH    = 4'd2;
  localparam logic [3:0] PH_TX_HIGH    = 4'd3;
  localparam logic [3:0] PH_TX_LOW     = 4'd4;
  localparam logic [3:0] PH_TXACK_HIGH = 4'd5;
  localparam logic [3:0] PH_TXACK_LOW  = 4'd6;
  localparam logic [3:0] PH_RX_LOW0    = 4'd7;
  localparam logic [3:0] PH_RX_HIGH    = 4'd8;
  localparam logic [3:0] PH_RX_LOW     = 4'd9;
  localparam logic [3:0] PH_RXACK_HIGH = 4'd10;
  localparam logic [3:0] PH_RXACK_LOW  = 4'd11;
  localparam logic [3:0] PH_STOP_HIGH  = 4'd12;

  // sub steps of one clock edge
  localparam logic [1:0] SUB_PRE  = 2'd0;
  localparam logic [1:0] SUB_WAIT = 2'd1;
  localparam logic [1:0] SUB_POST = 2'd2;

  // link status codes
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_ACK  = 2'd1;
  localparam logic [1:0] ST_NAK  = 2'd2;

  // classified item as queued between front and back
  typedef struct packed {
    logic        is_tick;
    logic        is_xfer;
    logic        is_probe;
    logic        is_write;
    logic        is_read;
    logic [6:0]  dev_addr;
    logic        read_dir;
    logic        use_start;
    logic        end_flag;
    logic [15:0] byte_count;
    logic [7:0]  wr_data;
    logic        sda_in;
    logic        scl_in;
  } item_t;

  // one result beat
  typedef struct packed {
    logic        scl_low;
    logic        sda_low;
    logic        busy_res;
    logic        accepted;
    logic [1:0]  link_status;
    logic [15:0] remaining;
    logic [7:0]  rx_byte;
    logic        rx_valid;
    logic        write_nak;
  } result_t;

endpackage

// ===== design/i2c_bit_level_master.sv =====
// top level of the i2c bit-level master
// joins the front queue and the bus sequencer; depends on i2cm_pkg,
// i2cm_front and i2cm_engine
//
//   channel   handshake          beat
//   input     push / full        action, address, flags, count, data, line levels
//   result    empty / pop        line drives, status, count, received byte
//   config    cfg_we             cfg_data -> clock delay
//
// one beat is taken per cycle while the result queue has room; the sequencer
// does one beat's step in a cycle. an input beat waits in the front queue, and
// its result is written into the result queue, to be popped, when it is taken.
// two-entry queues on each side let input and result stall apart.
// reset is synchronous; the clock delay comes back to ten ticks.
module i2c_bit_level_master
  import i2cm_pkg::*;
#(
  parameter int DELAY_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [15:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [2:0]  action,
  input  logic [6:0]  dev_addr,
  input  logic        read_dir,
  input  logic        use_start,
  input  logic        end_flag,
  input  logic [15:0] byte_count,
  input  logic [7:0]  wr_data,
  input  logic        sda_in,
  input  logic        scl_in,
  output logic        empty,
  input  logic        pop,
  output logic        scl_low,
  output logic        sda_low,
  output logic        busy_res,
  output logic        accepted,
  output logic [1:0]  link_status,
  output logic [15:0] remaining,
  output logic [7:0]  rx_byte,
  output logic        rx_valid,
  output logic        write_nak
);

  logic [DELAY_BITS-1:0] edge_delay;
  item_t                 item_in;
  item_t                 item_q;
  logic                  item_valid;
  logic                  item_take;
  result_t               res;

  // clock delay register
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_delay <= DELAY_BITS'(10);
    end else if (cfg_we) begin
      edge_delay <= cfg_data[DELAY_BITS-1:0];
    end
  end

  // classify the action of an incoming beat
  always_comb begin
    item_in.is_tick    = (action == ACT_TICK);
    item_in.is_xfer    = (action == ACT_XFER);
    item_in.is_probe   = (action == ACT_PROBE);
    item_in.is_write   = (action == ACT_WRITE);
    item_in.is_read    = (action == ACT_READ);
    item_in.dev_addr   = dev_addr;
    item_in.read_dir   = read_dir;
    item_in.use_start  = use_start;
    item_in.end_flag   = end_flag;
    item_in.byte_count = byte_count;
    item_in.wr_data    = wr_data;
    item_in.sda_in     = sda_in;
    item_in.scl_in     = scl_in;
  end

  i2cm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .item_in    (item_in),
    .item_valid (item_valid),
    .item_out   (item_q),
    .item_take  (item_take)
  );

  i2cm_engine #(
    .DELAY_BITS (DELAY_BITS)
  ) u_engine (
    .clk        (clk),
    .rst        (rst),
    .delay      (edge_delay),
    .item_valid (item_valid),
    .item       (item_q),
    .item_take  (item_take),
    .empty      (empty),
    .pop        (pop),
    .res_out    (res)
  );

  assign scl_low     = res.scl_low;
  assign sda_low     = res.sda_low;
  assign busy_res    = res.busy_res;
  assign accepted    = res.accepted;
  assign link_status = res.link_status;
  assign remaining   = res.remaining;
  assign rx_byte     = res.rx_byte;
  assign rx_valid    = res.rx_valid;
  assign write_nak   = res.write_nak;

endmodule

// ===== design/i2cm_front.sv =====
// front end: accepts input beats, already classified at the top level, and queues them
// depends on i2cm_pkg
module i2cm_front
  import i2cm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  item_t       item_in,
  output logic        item_valid,
  output item_t       item_out,
  input  logic        item_take
);

  item_t      slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       do_push;
  logic       do_pop;

  assign full       = (count == 2'd2);
  assign do_push    = push && !full;
  assign item_valid = (count != 2'd0);
  assign do_pop     = item_take && item_valid;
  assign item_out   = slots[rd_ptr];

  // two-entry queue storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= item_in;
    end
  end

  // queue pointers and fill
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== design/i2cm_engine.sv =====
// back end: bus sequencer, which carries out one queued beat per cycle unless the
// result queue is full, and a two-entry result queue; depends on i2cm_pkg
module i2cm_engine
  import i2cm_pkg::*;
#(
  parameter int DELAY_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [DELAY_BITS-1:0] delay,
  input  logic                  item_valid,
  input  item_t                 item,
  output logic                  item_take,
  output logic                  empty,
  input  logic                  pop,
  output result_t               res_out
);

  logic [3:0]            phase, phase_next;
  logic [1:0]            sub, sub_next;
  logic [DELAY_BITS-1:0] dcnt, dcnt_next;
  logic [3:0]            bit_count, bit_count_next;
  logic [7:0]            shift_byte, shift_byte_next;
  logic [15:0]           bytes_left, bytes_left_next;
  logic [1:0]            status_reg, status_reg_next;
  logic                  stop_on_end, stop_on_end_next;
  logic [2:0]            op_kind, op_kind_next;
  logic                  nak_seen, nak_seen_next;
  logic                  ack_latch, ack_latch_next;
  logic [7:0]            rx_reg, rx_reg_next;
  logic                  scl_drv, scl_drv_next;
  logic                  sda_drv, sda_drv_next;

  logic [DELAY_BITS-1:0] full_d;
  logic [DELAY_BITS-1:0] half_d;
  logic                  idle;
  logic                  ready;
  logic                  taken;
  logic                  rx_pulse;
  logic                  high_phase;
  logic                  ack;
  logic [3:0]            bc_inc;
  result_t               res_in;

  result_t    rq [2];
  logic       rq_wr, rq_rd;
  logic [1:0] rq_count;

  // edge wait lengths
  assign full_d = (delay == '0) ? {{(DELAY_BITS-1){1'b0}}, 1'b1} : delay;
  assign half_d = ((full_d >> 1) == '0) ? {{(DELAY_BITS-1){1'b0}}, 1'b1} : (full_d >> 1);

  assign idle       = (phase == PH_IDLE);
  assign ready      = idle && (status_reg == ST_ACK) && (bytes_left != 16'd0);
  assign high_phase = (phase == PH_RS_HIGH) || (phase == PH_TX_HIGH) ||
                      (phase == PH_TXACK_HIGH) || (phase == PH_RX_HIGH) ||
                      (phase == PH_RXACK_HIGH) || (phase == PH_STOP_HIGH);
  assign ack        = (ack_latch == 1'b0);
  assign bc_inc     = bit_count + 4'd1;

  assign item_take = item_valid && (rq_count != 2'd2);

  // sequencer step for one beat
  always_comb begin
    phase_next       = phase;
    sub_next         = sub;
    dcnt_next        = dcnt;
    bit_count_next   = bit_count;
    shift_byte_next  = shift_byte;
    bytes_left_next  = bytes_left;
    status_reg_next  = status_reg;
    stop_on_end_next = stop_on_end;
    op_kind_next     = op_kind;
    nak_seen_next    = nak_seen;
    ack_latch_next   = ack_latch;
    rx_reg_next      = rx_reg;
    scl_drv_next     = scl_drv;
    sda_drv_next     = sda_drv;
    taken            = 1'b0;
    rx_pulse         = 1'b0;
    if (item.is_tick) begin
      if (!idle) begin
        unique case (sub)
          SUB_PRE: begin
            if (dcnt > {{(DELAY_BITS-1){1'b0}}, 1'b1}) begin
              dcnt_next = dcnt - 1'b1;
            end else if (high_phase) begin
              scl_drv_next = 1'b0;
              sub_next     = SUB_WAIT;
            end else begin
              scl_drv_next = 1'b1;
              sub_next     = SUB_POST;
              dcnt_next    = full_d;
            end
          end
          SUB_WAIT: begin
            if (item.scl_in) begin
              sub_next  = SUB_POST;
              dcnt_next = full_d;
            end
          end
          default: begin
            if (dcnt > {{(DELAY_BITS-1){1'b0}}, 1'b1}) begin
              dcnt_next = dcnt - 1'b1;
            end else begin
              // edge finished: move to the next phase
              sub_next  = SUB_PRE;
              dcnt_next = half_d;
              unique case (phase)
                PH_START_LOW: begin
                  bit_count_next = 4'd0;
                  sda_drv_next   = ~shift_byte[7];
                  phase_next     = PH_TX_HIGH;
                end
                PH_RS_HIGH: begin
                  sda_drv_next = 1'b1;
                  phase_next   = PH_START_LOW;
                end
                PH_TX_HIGH: phase_next = PH_TX_LOW;
                PH_TX_LOW: begin
                  bit_count_next = bc_inc;
                  if (bc_inc < 4'd8) begin
                    sda_drv_next = ~shift_byte[3'd7 - bc_inc[2:0]];
                    phase_next   = PH_TX_HIGH;
                  end else begin
                    sda_drv_next = 1'b0;
                    phase_next   = PH_TXACK_HIGH;
                  end
                end
                PH_TXACK_HIGH: begin
                  ack_latch_next = item.sda_in;
                  phase_next     = PH_TXACK_LOW;
                end
                PH_TXACK_LOW: begin
                  if (op_kind == ACT_XFER && !ack) begin
                    status_reg_next = ST_NAK;
                    bytes_left_next = 16'd0;
                    sda_drv_next    = 1'b1;
                    phase_next      = PH_STOP_HIGH;
                  end else if (op_kind == ACT_PROBE) begin
                    status_reg_next = ack ? ST_ACK : ST_NAK;
                    bytes_left_next = 16'd0;
                    sda_drv_next    = 1'b1;
                    phase_next      = PH_STOP_HIGH;
                  end else begin
                    if (op_kind == ACT_XFER) begin
                      status_reg_next = ST_ACK;
                    end else begin
                      nak_seen_next = !ack;
                    end
                    if (stop_on_end && bytes_left == 16'd0) begin
                      sda_drv_next = 1'b1;
                      phase_next   = PH_STOP_HIGH;
                    end else begin
                      phase_next = PH_IDLE;
                    end
                  end
                end
                PH_RX_LOW0: begin
                  bit_count_next  = 4'd0;
                  shift_byte_next = 8'd0;
                  phase_next      = PH_RX_HIGH;
                end
                PH_RX_HIGH: begin
                  shift_byte_next = {shift_byte[6:0], item.sda_in};
                  phase_next      = PH_RX_LOW;
                end
                PH_RX_LOW: begin
                  bit_count_next = bc_inc;
                  if (bc_inc < 4'd8) begin
                    phase_next = PH_RX_HIGH;
                  end else begin
                    sda_drv_next = (bytes_left != 16'd0);
                    phase_next   = PH_RXACK_HIGH;
                  end
                end
                PH_RXACK_HIGH: phase_next = PH_RXACK_LOW;
                PH_RXACK_LOW: begin
                  sda_drv_next = 1'b0;
                  rx_reg_next  = shift_byte;
                  rx_pulse     = 1'b1;
                  if (stop_on_end && bytes_left == 16'd0) begin
                    sda_drv_next = 1'b1;
                    phase_next   = PH_STOP_HIGH;
                  end else begin
                    phase_next = PH_IDLE;
                  end
                end
                PH_STOP_HIGH: begin
                  sda_drv_next = 1'b0;
                  phase_next   = PH_IDLE;
                end
                default: phase_next = PH_IDLE;
              endcase
            end
          end
        endcase
      end
    end else if ((item.is_xfer || item.is_probe) && idle) begin
      taken           = 1'b1;
      op_kind_next    = item.is_xfer ? ACT_XFER : ACT_PROBE;
      shift_byte_next = {item.dev_addr, item.read_dir};
      bit_count_next  = 4'd0;
      sub_next        = SUB_PRE;
      dcnt_next       = half_d;
      if (item.is_xfer) begin
        bytes_left_next  = item.byte_count;
        stop_on_end_next = item.end_flag;
      end
      if (item.is_probe || item.use_start) begin
        sda_drv_next = 1'b1;
        phase_next   = PH_START_LOW;
      end else begin
        sda_drv_next = 1'b0;
        phase_next   = PH_RS_HIGH;
      end
    end else if ((item.is_write || item.is_read) && ready) begin
      taken           = 1'b1;
      bytes_left_next = bytes_left - 16'd1;
      bit_count_next  = 4'd0;
      sub_next        = SUB_PRE;
      dcnt_next       = half_d;
      if (item.is_write) begin
        op_kind_next    = ACT_WRITE;
        shift_byte_next = item.wr_data;
        sda_drv_next    = ~item.wr_data[7];
        phase_next      = PH_TX_HIGH;
      end else begin
        op_kind_next = ACT_READ;
        sda_drv_next = 1'b0;
        phase_next   = PH_RX_LOW0;
      end
    end
  end

  // result beat for this item
  always_comb begin
    res_in.scl_low     = scl_drv_next;
    res_in.sda_low     = sda_drv_next;
    res_in.busy_res    = (phase_next != PH_IDLE);
    res_in.accepted    = taken;
    res_in.link_status = status_reg_next;
    res_in.remaining   = bytes_left_next;
    res_in.rx_byte     = rx_reg_next;
    res_in.rx_valid    = rx_pulse;
    res_in.write_nak   = nak_seen_next;
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      sub         <= SUB_PRE;
      dcnt        <= '0;
      bit_count   <= 4'd0;
      shift_byte  <= 8'd0;
      bytes_left  <= 16'd0;
      status_reg  <= ST_IDLE;
      stop_on_end <= 1'b0;
      op_kind     <= ACT_TICK;
      nak_seen    <= 1'b0;
      ack_latch   <= 1'b0;
      rx_reg      <= 8'd0;
      scl_drv     <= 1'b0;
      sda_drv     <= 1'b0;
    end else if (item_take) begin
      phase       <= phase_next;
      sub         <= sub_next;
      dcnt        <= dcnt_next;
      bit_count   <= bit_count_next;
      shift_byte  <= shift_byte_next;
      bytes_left  <= bytes_left_next;
      status_reg  <= status_reg_next;
      stop_on_end <= stop_on_end_next;
      op_kind     <= op_kind_next;
      nak_seen    <= nak_seen_next;
      ack_latch   <= ack_latch_next;
      rx_reg      <= rx_reg_next;
      scl_drv     <= scl_drv_next;
      sda_drv     <= sda_drv_next;
    end
  end

  // result queue storage
  always_ff @(posedge clk) begin
    if (item_take) begin
      rq[rq_wr] <= res_in;
    end
  end

  assign empty   = (rq_count == 2'd0);
  assign res_out = rq[rq_rd];

  // result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr    <= 1'b0;
      rq_rd    <= 1'b0;
      rq_count <= 2'd0;
    end else begin
      if (item_take) rq_wr <= ~rq_wr;
      if (pop && !empty) rq_rd <= ~rq_rd;
      rq_count <= rq_count + {1'b0, item_take} - {1'b0, pop && !empty};
    end
  end

`ifndef SYNTH
  // result queue never overfills
  a_rq_bound: assert property (@(posedge clk) disable iff (rst) rq_count != 2'd3)
    else $error("result queue overfilled");

  // clock line is released while waiting on stretching
  a_wait_released: assert property (@(posedge clk) disable iff (rst)
    sub == SUB_WAIT |-> !scl_drv)
    else $error("clock driven low during stretch wait");

  // a taken beat always lands in the result queue
  a_take_lands: assert property (@(posedge clk) disable iff (rst)
    item_take && !(pop && !empty) |=> !empty)
    else $error("result beat lost");

  // idle sequencer never reports busy
  a_idle_busy: assert property (@(posedge clk) disable iff (rst)
    item_take && phase_next == PH_IDLE |-> !res_in.busy_res)
    else $error("busy flag while idle");
`endif

endmodule
